>>> src/encoder_speed_distance_estimator_unit_macros.svh
// assertion macros for the encoder speed and distance estimator checks
`ifndef ENCODER_SPEED_DISTANCE_ESTIMATOR_UNIT_MACROS_SVH
`define ENCODER_SPEED_DISTANCE_ESTIMATOR_UNIT_MACROS_SVH

// same-cycle implication
`define ESDE_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ESDE_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/esde_pkg.sv
// shared types and constants of the encoder speed and distance estimator
package esde_pkg;

	localparam int TICK_W  = 32;
	localparam int PULSE_W = 32;
	localparam int DIST_W  = 48;
	localparam int DPP_W   = 24;
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DEN_W   = 32;
	localparam int QUOT_W  = 48;

	localparam logic [DPP_W-1:0] DPP_RESET = 24'd65536;

	localparam logic signed [DIST_W-1:0] SAT_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] SAT_MIN = {1'b1, {(DIST_W-1){1'b0}}};

	// result status codes
	localparam logic [1:0] ST_UPDATED = 2'd0;
	localparam logic [1:0] ST_SKIPPED = 2'd1;
	localparam logic [1:0] ST_RESET   = 2'd2;

	// divider result: truncated quotient and sticky overflow
	typedef struct packed {
		logic               ovf;
		logic [QUOT_W-1:0] mag;
	} quot_t;

endpackage

>>> src/esde_mul.sv
// shared unsigned multiplier with registered product
module esde_mul (
	input  logic                         clk,
	input  logic [esde_pkg::MUL_A_W-1:0] a,
	input  logic [esde_pkg::MUL_B_W-1:0] b,
	output logic [esde_pkg::MUL_P_W-1:0] p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= esde_pkg::MUL_P_W'(a) * esde_pkg::MUL_P_W'(b);
	end

endmodule

>>> src/esde_div.sv
// iterative restoring divider, one quotient bit per cycle
module esde_div #(
	parameter int NUM_W = 66
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           num,
	input  logic [esde_pkg::DEN_W-1:0] den,
	output logic                       done,
	output esde_pkg::quot_t            quot
);

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	typedef enum logic {
		DV_IDLE,
		DV_RUN
	} dv_state_t;

	dv_state_t                   state_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        done_q;
	logic [NUM_W-1:0]            num_q;
	logic [esde_pkg::DEN_W-1:0]  den_q;
	logic [esde_pkg::DEN_W-1:0]  rem_q;
	logic [esde_pkg::QUOT_W-1:0] q_q;
	logic                        ovf_q;

	logic [esde_pkg::DEN_W:0]    trial;
	logic [esde_pkg::DEN_W:0]    diff;
	logic                        fits;

	// shift in the next numerator bit and try the subtract
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DV_IDLE: begin
					if (start) begin
						cnt_q   <= CNT_W'(NUM_W - 1);
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= DV_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (state_q == DV_RUN) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[esde_pkg::DEN_W-1:0] : trial[esde_pkg::DEN_W-1:0];
			q_q   <= {q_q[esde_pkg::QUOT_W-2:0], fits};
			ovf_q <= ovf_q | q_q[esde_pkg::QUOT_W-1];
		end
	end

	assign done     = done_q;
	assign quot.ovf = ovf_q;
	assign quot.mag = q_q;

endmodule

>>> src/encoder_speed_distance_estimator_unit.sv
// top level of the quadrature encoder speed and distance estimator
// Encoder speed and distance estimator (M-method). Each input word is either an
// update (func 0: counter sample plus millisecond timestamp) or a reset of the totals
// (func 1). An update takes the wrapping signed counter difference, adds it to the
// wrapping 32-bit pulse total, scales it by distance_per_pulse (Q8.16 cm, to be
// written through cfg_wen/cfg_wdata while idle by the user; the block does not
// enforce this) into a saturating 48-bit Q.16 distance total, and sets speed to
// step * TICKS_PER_SECOND / elapsed ticks, truncated toward zero and saturated. An
// update with no elapsed tick changes nothing and reports skipped. Each input word
// gives exactly one result word holding the state after it. One word is in flight at
// a time, in_ready is low while it is worked on. A reset or skipped word passes
// through S_FIN into the result register, and in_ready is high again in the cycle
// its result shows. An update is finished by the bit-serial divider on an NUM_W-bit
// dividend, NUM_W = 56 + clog2(TICKS_PER_SECOND + 1); one 32x24 multiplier is reused
// for the distance step and for the two partial products of the speed numerator. A
// result word still waiting for out_ready holds the finished word back in S_FIN.
module encoder_speed_distance_estimator_unit #(
	parameter int COUNTER_BITS     = 16,
	parameter int TICKS_PER_SECOND = 1000
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wen,
	input  logic [esde_pkg::DPP_W-1:0]           cfg_wdata,
	// input words
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 func,
	input  logic [15:0]                          counter_value,
	input  logic [esde_pkg::TICK_W-1:0]          tick_ms,
	// result words
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           status,
	output logic signed [esde_pkg::PULSE_W-1:0]  pulse_total,
	output logic signed [esde_pkg::DIST_W-1:0]   distance_total,
	output logic signed [esde_pkg::DIST_W-1:0]   speed
);

	// width of the tick rate and of the dividend
	localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
	localparam int NUM_W  = esde_pkg::MUL_P_W + TPS_W;
	localparam int WIDE_W = esde_pkg::MUL_P_W + esde_pkg::MUL_A_W;
	localparam int SUM_W  = esde_pkg::MUL_P_W + 2;
	localparam int HI_W   = esde_pkg::MUL_P_W - esde_pkg::MUL_A_W;
	localparam logic [esde_pkg::MUL_B_W-1:0] TPS_B = esde_pkg::MUL_B_W'(TICKS_PER_SECOND);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_STEP,
		S_ACC,
		S_MUL_LO,
		S_MUL_HI,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;

	// configuration register
	logic [esde_pkg::DPP_W-1:0] dpp_q;

	// block state
	logic [COUNTER_BITS-1:0]             prev_sample_q;
	logic [esde_pkg::TICK_W-1:0]         prev_tick_q;
	logic signed [esde_pkg::PULSE_W-1:0] pulse_q;
	logic signed [esde_pkg::DIST_W-1:0]  dist_q;
	logic signed [esde_pkg::DIST_W-1:0]  speed_q;
	logic [1:0]                          code_q;

	// result register
	logic                                out_valid_q;
	logic [1:0]                          out_status_q;
	logic signed [esde_pkg::PULSE_W-1:0] out_pulse_q;
	logic signed [esde_pkg::DIST_W-1:0]  out_dist_q;
	logic signed [esde_pkg::DIST_W-1:0]  out_speed_q;

	// per-word working registers
	logic [COUNTER_BITS-1:0]             delta_q;
	logic [COUNTER_BITS-1:0]             sample_q;
	logic [esde_pkg::TICK_W-1:0]         tick_q;
	logic [esde_pkg::TICK_W-1:0]         dt_q;
	logic [HI_W-1:0]                     mag_hi_q;
	logic [esde_pkg::MUL_P_W-1:0]        p_lo_q;

	// datapath nets
	logic [COUNTER_BITS-1:0]             sample;
	logic [COUNTER_BITS-1:0]             delta;
	logic [esde_pkg::TICK_W-1:0]         dt;
	logic                                neg;
	logic [COUNTER_BITS-1:0]             abs_delta;
	logic [esde_pkg::MUL_A_W-1:0]        mul_a;
	logic [esde_pkg::MUL_B_W-1:0]        mul_b;
	logic [esde_pkg::MUL_P_W-1:0]        mul_p;
	logic signed [SUM_W-1:0]             step;
	logic signed [SUM_W-1:0]             dist_sum;
	logic [SUM_W-esde_pkg::DIST_W:0]     dist_top;
	logic signed [esde_pkg::DIST_W-1:0]  dist_next;
	logic [WIDE_W-1:0]                   wide_num;
	logic                                div_start;
	logic                                div_done;
	esde_pkg::quot_t                     quot;
	logic                                quot_big;
	logic signed [esde_pkg::DIST_W-1:0]  speed_next;
	logic                                accept;
	logic                                load_out;

	assign accept = in_valid && in_ready;

	// wrapping counter difference and elapsed ticks
	assign sample = COUNTER_BITS'(counter_value);
	assign delta  = sample - prev_sample_q;
	assign dt     = tick_ms - prev_tick_q;

	// pulse magnitude for the unsigned multiplier
	assign neg       = delta_q[COUNTER_BITS-1];
	assign abs_delta = neg ? (~delta_q + 1'b1) : delta_q;

	// shared multiplier operands: step, then low and high speed partial products
	always_comb begin
		case (state_q)
			S_MUL_STEP: begin
				mul_a = esde_pkg::MUL_A_W'(abs_delta);
				mul_b = dpp_q;
			end
			S_ACC: begin
				mul_a = mul_p[esde_pkg::MUL_A_W-1:0];
				mul_b = TPS_B;
			end
			S_MUL_LO: begin
				mul_a = esde_pkg::MUL_A_W'(mag_hi_q);
				mul_b = TPS_B;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	esde_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	// signed distance step and saturating total, valid in S_ACC
	assign step      = neg ? -$signed({2'b00, mul_p}) : $signed({2'b00, mul_p});
	assign dist_sum  = SUM_W'(dist_q) + step;
	assign dist_top  = dist_sum[SUM_W-1:esde_pkg::DIST_W-1];
	assign dist_next = (&dist_top || ~|dist_top) ? dist_sum[esde_pkg::DIST_W-1:0]
		: (dist_sum[SUM_W-1] ? esde_pkg::SAT_MIN : esde_pkg::SAT_MAX);

	// dividend = step magnitude * tick rate, assembled in S_MUL_HI
	assign wide_num  = WIDE_W'(p_lo_q) + {mul_p, esde_pkg::MUL_A_W'(0)};
	assign div_start = (state_q == S_MUL_HI);

	esde_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (wide_num[NUM_W-1:0]),
		.den    (dt_q),
		.done   (div_done),
		.quot   (quot)
	);

	// speed sign and saturation
	assign quot_big   = quot.ovf | quot.mag[esde_pkg::QUOT_W-1];
	assign speed_next = neg ? (quot_big ? esde_pkg::SAT_MIN : -$signed(quot.mag))
		: (quot_big ? esde_pkg::SAT_MAX : $signed(quot.mag));

	assign load_out = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpp_q <= esde_pkg::DPP_RESET;
		end else if (cfg_wen) begin
			dpp_q <= cfg_wdata;
		end
	end

	// sequencer, block state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			prev_sample_q <= '0;
			prev_tick_q   <= '0;
			pulse_q       <= '0;
			dist_q        <= '0;
			speed_q       <= '0;
			code_q        <= esde_pkg::ST_UPDATED;
			out_valid_q   <= 1'b0;
			out_status_q  <= esde_pkg::ST_UPDATED;
			out_pulse_q   <= '0;
			out_dist_q    <= '0;
			out_speed_q   <= '0;
		end else begin
			// result word valid: set on load, cleared once taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func) begin
							// clear totals and restart the time base
							pulse_q       <= '0;
							dist_q        <= '0;
							speed_q       <= '0;
							prev_sample_q <= '0;
							prev_tick_q   <= tick_ms;
							code_q        <= esde_pkg::ST_RESET;
							state_q       <= S_FIN;
						end else if (dt == '0) begin
							code_q  <= esde_pkg::ST_SKIPPED;
							state_q <= S_FIN;
						end else begin
							state_q <= S_MUL_STEP;
						end
					end
				end
				S_MUL_STEP: state_q <= S_ACC;
				S_ACC: begin
					pulse_q       <= pulse_q + esde_pkg::PULSE_W'($signed(delta_q));
					prev_sample_q <= sample_q;
					dist_q        <= dist_next;
					state_q       <= S_MUL_LO;
				end
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						speed_q     <= speed_next;
						prev_tick_q <= tick_q;
						code_q      <= esde_pkg::ST_UPDATED;
						state_q     <= S_FIN;
					end
				end
				S_FIN: begin
					if (load_out) begin
						out_status_q <= code_q;
						out_pulse_q  <= pulse_q;
						out_dist_q   <= dist_q;
						out_speed_q  <= speed_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-word operands, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q  <= delta;
			sample_q <= sample;
			tick_q   <= tick_ms;
			dt_q     <= dt;
		end
		if (state_q == S_ACC) begin
			mag_hi_q <= mul_p[esde_pkg::MUL_P_W-1:esde_pkg::MUL_A_W];
		end
		if (state_q == S_MUL_LO) begin
			p_lo_q <= mul_p;
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign pulse_total    = out_pulse_q;
	assign distance_total = out_dist_q;
	assign speed          = out_speed_q;

endmodule

>>> src/esde_chk.sv
// port-level checker for the encoder speed and distance estimator, with its bind
`include "encoder_speed_distance_estimator_unit_macros.svh"

module esde_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [1:0]                          status,
	input logic signed [esde_pkg::PULSE_W-1:0] pulse_total,
	input logic signed [esde_pkg::DIST_W-1:0]  distance_total,
	input logic signed [esde_pkg::DIST_W-1:0]  speed
);

	// a stalled result word holds
	`ESDE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(pulse_total) && $stable(distance_total) && $stable(speed), "result word changed while stalled")

	// one word in flight: ready drops right after an accept
	`ESDE_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "input accepted while a word is in flight")

	// a reset word reports cleared totals and speed
	`ESDE_ASSERT_NOW(a_reset_clears, clk, arst_n, out_valid && (status == esde_pkg::ST_RESET), (pulse_total == '0) && (distance_total == '0) && (speed == '0), "reset word shows nonzero totals")

endmodule

bind encoder_speed_distance_estimator_unit esde_chk u_esde_chk (.*);
